// ===== hdl/pqd_pkg.sv =====
// shared types and constants for the process ready queue
package pqd_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_QUERY   = 2'd2,
      OP_REMOVE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } st_type;

   typedef enum logic {
      PH_IDLE = 1'b0,
      PH_EXEC = 1'b1
   } phase_type;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] start;
      logic [15:0] size;
   } slot_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic capture;
      logic enq;
      logic deq;
      logic rem;
   } cell_ctl_type;

endpackage

// ===== hdl/pqd_cell.sv =====
// one queue slot with its id comparator, priority link and shift path
module pqd_cell #(
   parameter int QUEUE_DEPTH = pqd_pkg::QUEUE_DEPTH_DEF,
   parameter int INDEX       = 0,
   localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  pqd_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]         count,
   input  logic [7:0]            key_pid,
   input  pqd_pkg::slot_type     new_slot,
   input  pqd_pkg::slot_type     nxt_slot,
   output pqd_pkg::slot_type     slot_out,
   input  logic                  hit_in,
   output logic                  hit_out,
   input  pqd_pkg::slot_type     sel_in,
   output pqd_pkg::slot_type     sel_out
);

   pqd_pkg::slot_type slot_ff, slot_in;
   logic              hit_ff, hit_in_d;
   logic              in_use, first, take, shift, load;

   assign in_use = count > CW'(INDEX);

   // compare against the key while the transaction is taken
   assign hit_in_d = in_use && (slot_ff.pid == key_pid);

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         hit_ff <= hit_in_d;
      end
   end

   assign hit_out = hit_in | hit_ff;
   assign first   = hit_ff & ~hit_in;
   assign take    = (ctl.deq && (INDEX == 0) && in_use) || (ctl.rem && first);
   assign shift   = (ctl.deq && (count != '0)) || (ctl.rem && hit_out);
   assign load    = ctl.enq && (count == CW'(INDEX));

   always_comb begin
      if (load) begin
         slot_in = new_slot;
      end else if (shift) begin
         slot_in = nxt_slot;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   assign slot_out = slot_ff;
   assign sel_out  = take ? (sel_in | slot_ff) : sel_in;

endmodule

// ===== hdl/process_ready_queue_with_delete.sv =====
// a taken transaction runs in the compare cycle; its result strobe is registered from it
// busy stays high for the compare cycle, so a new transaction is taken only once the last one has executed
// the id compare is registered in every cell, then the priority link and shift run
// across the row of cells in the compare cycle; the receiver cannot stall
// reset (synchronous, active high) empties the queue; slot contents are not cleared
module process_ready_queue_with_delete #(
   parameter int QUEUE_DEPTH = pqd_pkg::QUEUE_DEPTH_DEF,
   localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  logic [1:0]    req_mode,
   input  logic [7:0]    req_key_pid,
   input  logic [15:0]   req_entry_start,
   input  logic [15:0]   req_entry_size,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic          rsp_found,
   output logic [7:0]    rsp_out_pid,
   output logic [15:0]   rsp_out_start,
   output logic [15:0]   rsp_out_size,
   output logic [CW-1:0] rsp_occupancy
);

   // control state
   pqd_pkg::phase_type phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               rsp_valid_ff;

   // captured transaction
   pqd_pkg::op_type    op_ff;
   pqd_pkg::slot_type  new_ff;

   // result registers
   pqd_pkg::st_type    status_ff, status_in;
   logic               found_ff, found_in;
   pqd_pkg::slot_type  out_ff;
   logic [CW-1:0]      occ_ff;

   logic                  accept, exec, full, empty, hit_any;
   pqd_pkg::cell_ctl_type ctl;

   // row of cells: priority link and selected slot ripple from the front
   logic              hit_chain [QUEUE_DEPTH+1];
   pqd_pkg::slot_type sel_chain [QUEUE_DEPTH+1];
   pqd_pkg::slot_type nxt_chain [QUEUE_DEPTH+1];

   assign accept = start && !busy;
   assign full   = count_ff == CW'(QUEUE_DEPTH);
   assign empty  = count_ff == '0;

   // next state
   always_comb begin
      case (phase_ff)
         pqd_pkg::PH_IDLE: phase_in = accept ? pqd_pkg::PH_EXEC : pqd_pkg::PH_IDLE;
         pqd_pkg::PH_EXEC: phase_in = pqd_pkg::PH_IDLE;
         default:          phase_in = pqd_pkg::PH_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      case (phase_ff)
         pqd_pkg::PH_IDLE: begin
            busy = 1'b0;
            exec = 1'b0;
         end
         pqd_pkg::PH_EXEC: begin
            busy = 1'b1;
            exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
            exec = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pqd_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // hold the transaction for the compare cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= pqd_pkg::op_type'(req_mode);
         new_ff.pid   <= req_key_pid;
         new_ff.start <= req_entry_start;
         new_ff.size  <= req_entry_size;
      end
   end

   // cell controls, only one operation is live in the compare cycle
   always_comb begin
      ctl.capture = accept;
      ctl.enq     = exec && (op_ff == pqd_pkg::OP_ENQUEUE) && !full;
      ctl.deq     = exec && (op_ff == pqd_pkg::OP_DEQUEUE);
      ctl.rem     = exec && (op_ff == pqd_pkg::OP_REMOVE);
   end

   assign hit_chain[0]           = 1'b0;
   assign sel_chain[0]           = '0;
   assign nxt_chain[QUEUE_DEPTH] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      // each cell hands its slot to the cell in front for the shift
      pqd_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .INDEX       (i)
      ) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .count    (count_ff),
         .key_pid  (req_key_pid),
         .new_slot (new_ff),
         .nxt_slot (nxt_chain[i+1]),
         .slot_out (nxt_chain[i]),
         .hit_in   (hit_chain[i]),
         .hit_out  (hit_chain[i+1]),
         .sel_in   (sel_chain[i]),
         .sel_out  (sel_chain[i+1])
      );
   end

   assign hit_any = hit_chain[QUEUE_DEPTH];

   // result and new count
   always_comb begin
      status_in = pqd_pkg::ST_OK;
      found_in  = 1'b0;
      count_in  = count_ff;
      case (op_ff)
         pqd_pkg::OP_ENQUEUE: begin
            if (full) begin
               status_in = pqd_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
            end
         end
         pqd_pkg::OP_DEQUEUE: begin
            if (empty) begin
               status_in = pqd_pkg::ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         pqd_pkg::OP_QUERY: begin
            if (hit_any) begin
               found_in = 1'b1;
            end else begin
               status_in = pqd_pkg::ST_MISSING;
            end
         end
         pqd_pkg::OP_REMOVE: begin
            if (hit_any) begin
               found_in = 1'b1;
               count_in = count_ff - CW'(1);
            end else begin
               status_in = pqd_pkg::ST_MISSING;
            end
         end
         default: begin
            status_in = pqd_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= exec;
         if (exec) begin
            count_ff <= count_in;
         end
      end
   end

   // result payload, one strobe cycle per transaction
   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         out_ff    <= sel_chain[QUEUE_DEPTH];
         occ_ff    <= count_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_found     = found_ff;
   assign rsp_out_pid   = out_ff.pid;
   assign rsp_out_start = out_ff.start;
   assign rsp_out_size  = out_ff.size;
   assign rsp_occupancy = occ_ff;

`ifndef SYNTHESIS
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(exec))
      else $error("result strobe without a compare cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pqd_pkg::ST_FULL) |-> rsp_occupancy == CW'(QUEUE_DEPTH))
      else $error("full status with room left");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("not busy after a transaction was taken");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == pqd_pkg::ST_OK)
      else $error("found with an error status");
`endif

endmodule
